// ----- rtl/pud_pkg.sv -----
// Shared types and widths for the percent/UTF-8 URL decoder.
`timescale 1ns / 1ps

package pud_pkg;

   localparam int UNIT_W = 16;

   // Per-item control handed to both decode stages
   typedef struct packed {
      logic advance;   // process the held item (output not stopped)
      logic clear;     // last item of the string: return to reset state
   } stage_ctrl_type;

   // Escape stage result for the held item
   typedef struct packed {
      logic              unit_ready;   // a unit goes on to the UTF-8 stage
      logic [UNIT_W-1:0] unit_value;
      logic              open;         // escape still open after this item
   } esc_result_type;

   // UTF-8 stage result for the held item
   typedef struct packed {
      logic              have;         // a character completes
      logic [UNIT_W-1:0] ch;
      logic              open;         // sequence still open after this item
   } utf8_result_type;

endpackage

// ----- rtl/pud_escape.sv -----
// Percent-escape and plus-to-space stage with its escape state.
`timescale 1ns / 1ps

module pud_escape (
   input  logic                          clock,
   input  logic                          reset,
   input  pud_pkg::stage_ctrl_type       ctrl,
   input  logic [pud_pkg::UNIT_W-1:0]    code_unit,
   output pud_pkg::esc_result_type       result
);

   typedef enum logic [1:0] {
      ESC_IDLE   = 2'd0,
      ESC_FIRST  = 2'd1,
      ESC_SECOND = 2'd2
   } esc_phase_type;

   localparam logic [pud_pkg::UNIT_W-1:0] CHAR_PERCENT = 16'h0025;
   localparam logic [pud_pkg::UNIT_W-1:0] CHAR_PLUS    = 16'h002B;
   localparam logic [pud_pkg::UNIT_W-1:0] CHAR_SPACE   = 16'h0020;

   esc_phase_type phase_ff, phase_in, phase_next;
   logic [7:0]    first_digit_ff, first_digit_in, first_digit_next;
   logic [7:0]    digit;

   // Map a digit character to 0..35; anything else keeps its low byte
   function automatic logic [7:0] map_digit(input logic [7:0] b);
      logic [7:0] r;
      if (b >= 8'd48 && b <= 8'd57) begin
         r = b - 8'd48;
      end else if (b >= 8'd65 && b <= 8'd90) begin
         r = b - 8'd55;
      end else if (b >= 8'd97 && b <= 8'd122) begin
         r = b - 8'd87;
      end else begin
         r = b;
      end
      return r;
   endfunction

   assign digit = map_digit(code_unit[7:0]);

   // Decode the held unit against the escape phase
   always_comb begin
      phase_next        = ESC_IDLE;
      first_digit_next  = first_digit_ff;
      result.unit_ready = 1'b0;
      result.unit_value = '0;
      case (phase_ff)
         ESC_FIRST: begin
            first_digit_next = digit;
            phase_next       = ESC_SECOND;
         end
         ESC_SECOND: begin
            result.unit_ready = 1'b1;
            result.unit_value = {4'h0, first_digit_ff, 4'h0} | {8'h00, digit};
         end
         default: begin
            if (code_unit == CHAR_PERCENT) begin
               phase_next = ESC_FIRST;
            end else if (code_unit == CHAR_PLUS) begin
               result.unit_ready = 1'b1;
               result.unit_value = CHAR_SPACE;
            end else begin
               result.unit_ready = 1'b1;
               result.unit_value = code_unit;
            end
         end
      endcase
      result.open = (phase_next != ESC_IDLE);
   end

   // Advance on a processed item, drop back to idle at end of string
   always_comb begin
      phase_in       = phase_ff;
      first_digit_in = first_digit_ff;
      if (ctrl.clear) begin
         phase_in       = ESC_IDLE;
         first_digit_in = '0;
      end else if (ctrl.advance) begin
         phase_in       = phase_next;
         first_digit_in = first_digit_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= ESC_IDLE;
         first_digit_ff <= '0;
      end else begin
         phase_ff       <= phase_in;
         first_digit_ff <= first_digit_in;
      end
   end

endmodule

// ----- rtl/pud_utf8.sv -----
// UTF-8 to UTF-16 reassembly stage with its sequence state.
`timescale 1ns / 1ps

module pud_utf8 (
   input  logic                          clock,
   input  logic                          reset,
   input  pud_pkg::stage_ctrl_type       ctrl,
   input  logic                          unit_ready,
   input  logic [pud_pkg::UNIT_W-1:0]    unit_value,
   output pud_pkg::utf8_result_type      result
);

   typedef enum logic [1:0] {
      SEQ_NONE = 2'd0,
      SEQ_LAST = 2'd1,
      SEQ_TWO  = 2'd2
   } seq_state_type;

   seq_state_type                 pending_ff, pending_in, pending_next;
   logic [pud_pkg::UNIT_W-1:0]    partial_ff, partial_in, partial_next;
   logic [pud_pkg::UNIT_W-1:0]    u;

   assign u = unit_value;

   // Fold the unit into the pending sequence or start a new one
   always_comb begin
      pending_next = pending_ff;
      partial_next = partial_ff;
      result.have  = 1'b0;
      result.ch    = '0;
      if (unit_ready) begin
         case (pending_ff)
            SEQ_TWO: begin
               partial_next = partial_ff | {4'h0, u[5:0], 6'h00};
               pending_next = SEQ_LAST;
            end
            SEQ_LAST: begin
               result.have  = 1'b1;
               result.ch    = partial_ff | {10'h000, u[5:0]};
               pending_next = SEQ_NONE;
               partial_next = '0;
            end
            default: begin
               if (u[15:7] == 9'h000) begin
                  result.have = 1'b1;
                  result.ch   = u;
               end else if (u[15:4] == 12'h00E) begin
                  partial_next = {u[3:0], 12'h000};
                  pending_next = SEQ_TWO;
               end else if (u <= 16'h00DF) begin
                  partial_next = {5'h00, u[4:0], 6'h00};
                  pending_next = SEQ_LAST;
               end else begin
                  // lead bytes above 0xEF pass through as characters
                  result.have = 1'b1;
                  result.ch   = u;
               end
            end
         endcase
      end
      result.open = (pending_next != SEQ_NONE);
   end

   // Hold unless a unit arrives; clear at end of string
   always_comb begin
      pending_in = pending_ff;
      partial_in = partial_ff;
      if (ctrl.clear) begin
         pending_in = SEQ_NONE;
         partial_in = '0;
      end else if (ctrl.advance) begin
         pending_in = pending_next;
         partial_in = partial_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= SEQ_NONE;
         partial_ff <= '0;
      end else begin
         pending_ff <= pending_in;
         partial_ff <= partial_in;
      end
   end

endmodule

// ----- rtl/percent_utf8_url_decoder.sv -----
// Path: input register, then result register, from input transfer to result valid.
// Throughput: one unit per cycle if not stalled; escape and UTF-8 state update together.
// A unit that completes no character and is not last gives no result but is still consumed.
// A stalled result register holds the held input item, and input ready follows it.
// Synchronous active-high reset empties both registers and clears all decode state.
// Top level of the percent/UTF-8 URL decoder.
`timescale 1ns / 1ps

module percent_utf8_url_decoder (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [pud_pkg::UNIT_W-1:0]    req_code_unit,
   input  logic                          req_is_last,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [pud_pkg::UNIT_W-1:0]    rsp_char_out,
   output logic                          rsp_char_valid,
   output logic                          rsp_end_of_string,
   output logic                          rsp_truncated
);

   logic                         in_valid_ff, in_valid_in;
   logic [pud_pkg::UNIT_W-1:0]   in_unit_ff, in_unit_in;
   logic                         in_last_ff, in_last_in;
   logic                         stopped_ff, stopped_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [pud_pkg::UNIT_W-1:0]   rsp_char_ff, rsp_char_in;
   logic                         rsp_cvalid_ff, rsp_cvalid_in;
   logic                         rsp_eos_ff, rsp_eos_in;
   logic                         rsp_trunc_ff, rsp_trunc_in;

   logic                         proc;
   logic                         stop_now;
   logic                         have;
   logic                         stopped_next;
   logic                         emit;
   pud_pkg::stage_ctrl_type      ctrl;
   pud_pkg::esc_result_type      esc;
   pud_pkg::utf8_result_type     utf;

   // Process the held item only when the result register can take a transfer
   assign proc      = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || proc;

   assign ctrl.advance = proc && !stopped_ff;
   assign ctrl.clear   = proc && in_last_ff;

   pud_escape u_escape (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .code_unit (in_unit_ff),
      .result    (esc)
   );

   pud_utf8 u_utf8 (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .unit_ready (esc.unit_ready),
      .unit_value (esc.unit_value),
      .result     (utf)
   );

   // A decoded zero character stops output until the end of the string
   assign stop_now     = !stopped_ff && utf.have && (utf.ch == '0);
   assign have         = !stopped_ff && utf.have && !stop_now;
   assign stopped_next = stopped_ff || stop_now;
   assign emit         = proc && (in_last_ff || have);

   // Input register
   always_comb begin
      in_valid_in = in_valid_ff;
      in_unit_in  = in_unit_ff;
      in_last_in  = in_last_ff;
      if (req_ready) begin
         in_valid_in = req_valid;
         in_unit_in  = req_code_unit;
         in_last_in  = req_is_last;
      end
   end

   // Stop flag
   always_comb begin
      stopped_in = stopped_ff;
      if (ctrl.clear) begin
         stopped_in = 1'b0;
      end else if (proc) begin
         stopped_in = stopped_next;
      end
   end

   // Result register: load on emit, drop after the transfer
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_char_in   = rsp_char_ff;
      rsp_cvalid_in = rsp_cvalid_ff;
      rsp_eos_in    = rsp_eos_ff;
      rsp_trunc_in  = rsp_trunc_ff;
      if (emit) begin
         rsp_valid_in  = 1'b1;
         rsp_char_in   = have ? utf.ch : '0;
         rsp_cvalid_in = have;
         rsp_eos_in    = in_last_ff;
         rsp_trunc_in  = in_last_ff && !stopped_next && (esc.open || utf.open);
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         stopped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         stopped_ff   <= stopped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      in_unit_ff    <= in_unit_in;
      in_last_ff    <= in_last_in;
      rsp_char_ff   <= rsp_char_in;
      rsp_cvalid_ff <= rsp_cvalid_in;
      rsp_eos_ff    <= rsp_eos_in;
      rsp_trunc_ff  <= rsp_trunc_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_char_out      = rsp_char_ff;
   assign rsp_char_valid    = rsp_cvalid_ff;
   assign rsp_end_of_string = rsp_eos_ff;
   assign rsp_truncated     = rsp_trunc_ff;

   // A result without end of string always carries a non-zero character
   a_mid_result_has_char: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_end_of_string |-> rsp_char_valid && (rsp_char_out != '0))
      else $error("result without end of string lacks a character");

   // Truncation is only reported on the end-of-string result
   a_trunc_at_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_truncated |-> rsp_end_of_string)
      else $error("truncated flag outside end of string");

   // No character means a zero payload
   a_empty_char_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_char_valid |-> rsp_char_out == '0)
      else $error("empty result carries a character");

   // The last item leaves the stop flag cleared
   a_last_clears_stop: assert property (@(posedge clock) disable iff (reset)
      proc && in_last_ff |=> !stopped_ff)
      else $error("stop flag survives end of string");

   // Processing an item with the result slot full would lose a result
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      emit |-> !rsp_valid_ff || rsp_ready)
      else $error("result register overwritten while stalled");

endmodule
